### rtl/assert_macros.svh
// assertion macros used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

### rtl/rv32ie_pkg.sv
// types and constants of the instruction executor
`timescale 1ns / 1ps
package rv32ie_pkg;
   typedef enum logic [5:0] {
      OP_ADD = 6'd0, OP_SUB = 6'd1, OP_AND = 6'd2, OP_OR = 6'd3, OP_SLT = 6'd4,
      OP_SLTU = 6'd5, OP_SLL = 6'd6, OP_SRL = 6'd7, OP_SRA = 6'd8, OP_ADDI = 6'd9,
      OP_SLTI = 6'd10, OP_SLTIU = 6'd11, OP_XORI = 6'd12, OP_ORI = 6'd13,
      OP_ANDI = 6'd14, OP_SLLI = 6'd15, OP_SRLI = 6'd16, OP_SRAI = 6'd17,
      OP_LUI = 6'd18, OP_AUIPC = 6'd19, OP_LB = 6'd20, OP_LH = 6'd21, OP_LW = 6'd22,
      OP_LBU = 6'd23, OP_LHU = 6'd24, OP_SB = 6'd25, OP_SW = 6'd26, OP_BEQ = 6'd27,
      OP_BNE = 6'd28, OP_BLT = 6'd29, OP_BGE = 6'd30, OP_BLTU = 6'd31,
      OP_BGEU = 6'd32, OP_JAL = 6'd33, OP_JALR = 6'd34, OP_MUL = 6'd35,
      OP_DIV = 6'd36, OP_HALT = 6'd37
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CLEAR, ST_READ, ST_EXEC, ST_MUL, ST_DIV, ST_MEM, ST_OUT
   } state_type;

   typedef struct packed {
      logic [5:0]  operation;
      logic [4:0]  dest_index;
      logic [4:0]  src1_index;
      logic [4:0]  src2_index;
      logic [31:0] immediate;
   } req_type;

   typedef struct packed {
      logic [31:0] executed_pc;
      logic [31:0] next_pc;
      logic        dest_written;
      logic [4:0]  write_index;
      logic [31:0] write_value;
      logic        halted;
   } rsp_type;
endpackage

### rtl/rv32ie_channel_if.sv
// valid/ready channels of the executor
`timescale 1ns / 1ps
interface rv32ie_req_if;
   logic                 valid;
   logic                 ready;
   rv32ie_pkg::req_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rv32ie_rsp_if;
   logic                 valid;
   logic                 ready;
   rv32ie_pkg::rsp_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rv32ie_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### rtl/rv32i_instruction_executor.sv
// channel | direction | transfer carries
// req     | in        | operation, register indices, immediate
// rsp     | out       | pcs, register write, halt flag
// csr     | in        | start address (also loads the pc)
// an item passes read, execute, memory write and result; mul and div wait on their unit;
// the register file and data memory are single-write synchronous rams with registered reads
// after reset a clearing pass zeroes both memories, its address counting up to the larger
// of MEM_WORDS - 1 and 31; no req taken then
// rsp holds until taken; the next req is accepted in the cycle the result transfers
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rv32i_instruction_executor #(
   parameter int MEM_WORDS = 1024
) (
   input logic clock,
   input logic reset,
   rv32ie_req_if.sink   req,
   rv32ie_rsp_if.source rsp,
   rv32ie_csr_if.sink   csr
);
   localparam int AW = $clog2(MEM_WORDS);
   localparam int CLR_LAST = (MEM_WORDS > 32) ? MEM_WORDS - 1 : 31;

   rv32ie_pkg::state_type state_ff, state_in;
   rv32ie_pkg::req_type   item_ff, item_in;
   rv32ie_pkg::rsp_type   out_ff, out_in;

   logic [31:0] rf_mem [32];
   logic [31:0] dm_mem [MEM_WORDS];
   logic [31:0] rf_a_ff, rf_b_ff, dm_q_ff;
   logic [31:0] pc_ff, pc_in;
   logic        stop_ff, stop_in;
   logic [AW:0] clr_ff, clr_in;
   logic [31:0] a, b, imm, addr, val_ff, val_in, next_ff, next_in, prod_ff;
   logic        wr_ff, wr_in;
   logic [AW-1:0] dm_waddr, dm_raddr;
   logic [31:0] dm_wdata, div_q;
   logic        dm_we, rf_we;
   logic [4:0]  rf_waddr;
   logic [31:0] rf_wdata;
   logic [4:0]  lane;
   logic        div_start, div_done;
   logic [7:0]  byte_val;
   logic [31:0] load_val, commit_val;
   logic        is_load;

   assign a = (item_ff.src1_index == 5'd0) ? 32'd0 : rf_a_ff;
   assign b = (item_ff.src2_index == 5'd0) ? 32'd0 : rf_b_ff;
   assign imm = item_ff.immediate;
   assign addr = a + imm;
   assign dm_raddr = addr[AW+1:2];
   assign lane = {addr[1:0], 3'b000};
   assign byte_val = 8'(dm_q_ff >> lane);

   rv32ie_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(a), .divisor(b), .done(div_done), .quotient(div_q)
   );

   // loads are formatted at commit, once the word read at the final address is back
   always_comb begin
      is_load = 1'b1;
      load_val = dm_q_ff;
      case (item_ff.operation)
         rv32ie_pkg::OP_LB: load_val = {{24{byte_val[7]}}, byte_val};
         rv32ie_pkg::OP_LH: load_val = addr[1] ? {{16{dm_q_ff[31]}}, dm_q_ff[31:16]}
                                               : {{16{dm_q_ff[15]}}, dm_q_ff[15:0]};
         rv32ie_pkg::OP_LW: load_val = dm_q_ff;
         rv32ie_pkg::OP_LBU: load_val = {24'd0, byte_val};
         rv32ie_pkg::OP_LHU: load_val = addr[1] ? {16'd0, dm_q_ff[31:16]}
                                                : {16'd0, dm_q_ff[15:0]};
         default: is_load = 1'b0;
      endcase
      commit_val = is_load ? load_val : val_ff;
   end

   always_comb begin
      state_in = state_ff; item_in = item_ff; out_in = out_ff; pc_in = pc_ff;
      stop_in = stop_ff; clr_in = clr_ff; val_in = val_ff; next_in = next_ff;
      wr_in = wr_ff; div_start = 1'b0;
      dm_we = 1'b0; dm_waddr = dm_raddr; dm_wdata = b;
      rf_we = 1'b0; rf_waddr = item_ff.dest_index; rf_wdata = val_ff;
      req.ready = 1'b0;
      unique case (state_ff)
         rv32ie_pkg::ST_CLEAR: begin
            dm_we = 1'b1; dm_waddr = clr_ff[AW-1:0]; dm_wdata = 32'd0;
            rf_we = 1'b1; rf_waddr = clr_ff[4:0]; rf_wdata = 32'd0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(CLR_LAST)) state_in = rv32ie_pkg::ST_IDLE;
         end
         rv32ie_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               item_in = req.payload;
               state_in = rv32ie_pkg::ST_READ;
            end
         end
         rv32ie_pkg::ST_READ: state_in = rv32ie_pkg::ST_EXEC;
         rv32ie_pkg::ST_EXEC: begin
            next_in = pc_ff + 32'd4; wr_in = 1'b1; val_in = 32'd0;
            state_in = rv32ie_pkg::ST_MEM;
            case (item_ff.operation)
               rv32ie_pkg::OP_ADD: val_in = a + b;
               rv32ie_pkg::OP_SUB: val_in = a - b;
               rv32ie_pkg::OP_AND: val_in = a & b;
               rv32ie_pkg::OP_OR: val_in = a | b;
               rv32ie_pkg::OP_SLT: val_in = {31'd0, $signed(a) < $signed(b)};
               rv32ie_pkg::OP_SLTU: val_in = {31'd0, a < b};
               rv32ie_pkg::OP_SLL: val_in = a << b[4:0];
               rv32ie_pkg::OP_SRL: val_in = a >> b[4:0];
               rv32ie_pkg::OP_SRA: val_in = 32'($signed(a) >>> b[4:0]);
               rv32ie_pkg::OP_ADDI: val_in = a + imm;
               rv32ie_pkg::OP_SLTI: val_in = {31'd0, $signed(a) < $signed(imm)};
               rv32ie_pkg::OP_SLTIU: val_in = {31'd0, a < imm};
               rv32ie_pkg::OP_XORI: val_in = a ^ imm;
               rv32ie_pkg::OP_ORI: val_in = a | imm;
               rv32ie_pkg::OP_ANDI: val_in = a & imm;
               rv32ie_pkg::OP_SLLI: val_in = a << imm[4:0];
               rv32ie_pkg::OP_SRLI: val_in = a >> imm[4:0];
               rv32ie_pkg::OP_SRAI: val_in = 32'($signed(a) >>> imm[4:0]);
               rv32ie_pkg::OP_LUI: val_in = {imm[19:0], 12'd0};
               rv32ie_pkg::OP_AUIPC: val_in = pc_ff + {imm[19:0], 12'd0};
               // load value comes from the memory word at commit
               rv32ie_pkg::OP_LB, rv32ie_pkg::OP_LH, rv32ie_pkg::OP_LW,
               rv32ie_pkg::OP_LBU, rv32ie_pkg::OP_LHU: val_in = 32'd0;
               rv32ie_pkg::OP_SB, rv32ie_pkg::OP_SW: wr_in = 1'b0;
               rv32ie_pkg::OP_BEQ: begin wr_in = 1'b0; if (a == b) next_in = pc_ff + imm; end
               rv32ie_pkg::OP_BNE: begin wr_in = 1'b0; if (a != b) next_in = pc_ff + imm; end
               rv32ie_pkg::OP_BLT: begin
                  wr_in = 1'b0; if ($signed(a) < $signed(b)) next_in = pc_ff + imm;
               end
               rv32ie_pkg::OP_BGE: begin
                  wr_in = 1'b0; if ($signed(a) >= $signed(b)) next_in = pc_ff + imm;
               end
               rv32ie_pkg::OP_BLTU: begin wr_in = 1'b0; if (a < b) next_in = pc_ff + imm; end
               rv32ie_pkg::OP_BGEU: begin wr_in = 1'b0; if (a >= b) next_in = pc_ff + imm; end
               rv32ie_pkg::OP_JAL: begin val_in = pc_ff + 32'd4; next_in = pc_ff + imm; end
               rv32ie_pkg::OP_JALR: begin
                  val_in = pc_ff + 32'd4; next_in = {addr[31:1], 1'b0};
               end
               rv32ie_pkg::OP_MUL: state_in = rv32ie_pkg::ST_MUL;
               rv32ie_pkg::OP_DIV: begin
                  div_start = 1'b1; state_in = rv32ie_pkg::ST_DIV;
               end
               rv32ie_pkg::OP_HALT: begin wr_in = 1'b0; next_in = pc_ff; end
               default: wr_in = 1'b0;
            endcase
            if (stop_ff) begin
               wr_in = 1'b0; next_in = pc_ff; state_in = rv32ie_pkg::ST_MEM;
               div_start = 1'b0;
            end
            if (item_ff.dest_index == 5'd0) wr_in = 1'b0;
         end
         rv32ie_pkg::ST_MUL: begin
            val_in = prod_ff; state_in = rv32ie_pkg::ST_MEM;
         end
         rv32ie_pkg::ST_DIV: begin
            if (div_done) begin
               val_in = div_q; state_in = rv32ie_pkg::ST_MEM;
            end
         end
         rv32ie_pkg::ST_MEM: begin
            // commit: stores, register write, pc, response payload
            rf_wdata = commit_val;
            if (!stop_ff) begin
               if (item_ff.operation == rv32ie_pkg::OP_SW) dm_we = 1'b1;
               if (item_ff.operation == rv32ie_pkg::OP_SB) begin
                  dm_we = 1'b1;
                  dm_wdata = (dm_q_ff & ~(32'hFF << lane)) | ({24'd0, b[7:0]} << lane);
               end
               if (item_ff.operation == rv32ie_pkg::OP_HALT) stop_in = 1'b1;
               rf_we = wr_ff;
               pc_in = next_ff;
            end
            out_in.executed_pc = pc_ff;
            out_in.next_pc = next_ff;
            out_in.dest_written = wr_ff;
            out_in.write_index = wr_ff ? item_ff.dest_index : 5'd0;
            out_in.write_value = wr_ff ? commit_val : 32'd0;
            out_in.halted = stop_ff || (item_ff.operation == rv32ie_pkg::OP_HALT);
            state_in = rv32ie_pkg::ST_OUT;
         end
         rv32ie_pkg::ST_OUT: begin
            if (rsp.ready) begin
               req.ready = 1'b1;
               if (req.valid) begin
                  item_in = req.payload; state_in = rv32ie_pkg::ST_READ;
               end else begin
                  state_in = rv32ie_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = rv32ie_pkg::ST_IDLE;
      endcase
      if (csr.valid) pc_in = csr.payload;
   end

   assign csr.ready = 1'b1;
   assign rsp.valid = (state_ff == rv32ie_pkg::ST_OUT);
   assign rsp.payload = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rv32ie_pkg::ST_CLEAR;
         pc_ff    <= 32'd0;
         stop_ff  <= 1'b0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         stop_ff  <= stop_in;
         clr_ff   <= clr_in;
      end
      item_ff <= item_in; out_ff <= out_in; val_ff <= val_in;
      next_ff <= next_in; wr_ff <= wr_in;
      prod_ff <= a * b;
   end

   // register file ram: two read ports, one write port
   always_ff @(posedge clock) begin
      if (rf_we) rf_mem[rf_waddr] <= rf_wdata;
      rf_a_ff <= rf_mem[item_ff.src1_index];
      rf_b_ff <= rf_mem[item_ff.src2_index];
   end

   // data memory ram, read address follows rs1 + imm
   always_ff @(posedge clock) begin
      if (dm_we) dm_mem[dm_waddr] <= dm_wdata;
      dm_q_ff <= dm_mem[dm_raddr];
   end

   `ASSERT_IMPL(a_rsp_only_out, clock, reset, rsp.valid,
      state_ff == rv32ie_pkg::ST_OUT)
   `ASSERT_IMPL(a_no_x0_write, clock, reset, rsp.valid && rsp.payload.dest_written,
      rsp.payload.write_index != 5'd0)
   `ASSERT_NEXT(a_halt_sticky, clock, reset, stop_ff && !csr.valid, stop_ff)
endmodule

### rtl/rv32ie_divider.sv
// radix-2 signed divider, one quotient bit per cycle
`timescale 1ns / 1ps
module rv32ie_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);
   logic [31:0] rem_ff, rem_in, quo_ff, quo_in, dsr_ff, dsr_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in, busy_ff, busy_in, spec_ff, spec_in;
   logic [31:0] spec_val_ff, spec_val_in;
   logic [32:0] trial;
   logic [31:0] ma, mb;

   always_comb begin
      ma = dividend[31] ? 32'd0 - dividend : dividend;
      mb = divisor[31] ? 32'd0 - divisor : divisor;
      trial = {rem_ff, quo_ff[31]} - {1'b0, dsr_ff};
      rem_in = rem_ff; quo_in = quo_ff; dsr_in = dsr_ff; cnt_in = cnt_ff;
      neg_in = neg_ff; busy_in = busy_ff; spec_in = spec_ff; spec_val_in = spec_val_ff;
      done = 1'b0;
      if (start) begin
         busy_in = 1'b1; cnt_in = 6'd0; rem_in = 32'd0; quo_in = ma; dsr_in = mb;
         neg_in = dividend[31] ^ divisor[31];
         spec_in = (divisor == 32'd0)
            || (dividend == 32'h8000_0000 && divisor == 32'hFFFF_FFFF);
         spec_val_in = (divisor == 32'd0) ? 32'hFFFF_FFFF : 32'h8000_0000;
      end else if (busy_ff) begin
         if (cnt_ff == 6'd32) begin
            done = 1'b1;
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + 6'd1;
            if (!trial[32]) begin
               rem_in = trial[31:0];
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = {rem_ff[30:0], quo_ff[31]};
               quo_in = {quo_ff[30:0], 1'b0};
            end
         end
      end
   end

   assign quotient = spec_ff ? spec_val_ff : (neg_ff ? 32'd0 - quo_ff : quo_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in; quo_ff <= quo_in; dsr_ff <= dsr_in; neg_ff <= neg_in;
      spec_ff <= spec_in; spec_val_ff <= spec_val_in;
   end
endmodule
